// ===== design/vrot_pkg.sv =====
// Shared constants and types for the vector rotation unit.
package vrot_pkg;

   // Width of the CORDIC datapath (Q2.30 trig values and angle residual)
   localparam int TRIG_W = 34;

   // 0.6072529350 in Q2.30: start value that cancels the CORDIC gain
   localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;

   // Rounding offset for the Q2.30 product sums
   localparam int HALF_Q30 = 536870912;

   // Fraction bits of the trig values
   localparam int TRIG_FRAC = 30;

   // Width of one multiplier slice of a coordinate
   localparam int SLICE_W = 16;

   // atan(2^-i) in units of 2^-32 turn
   localparam logic [31:0] ATAN_TURN32 [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   typedef enum logic [1:0] {
      OP_PITCH = 2'd0,
      OP_YAW   = 2'd1,
      OP_ROLL  = 2'd2,
      OP_PASS  = 2'd3
   } axis_type;

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

endpackage

// ===== design/vector_rotate_about_axis_unit.sv =====
// Rotates a Q16.16 vector about the x, y or z axis by a binary angle.
//
// Request channel (req_valid/req_ready) carries an axis code, an angle where
// 2^ANGLE_WIDTH is one full turn, and the three coordinates. Response channel
// (rsp_valid/rsp_ready) returns the rotated vector and a flag raised when a
// rotated component was clipped to the coordinate range. Axis code 3 returns
// the vector unchanged.
// The pipeline has one input stage, one stage per CORDIC iteration, then
// quadrant restore, slice multiply, slice combine and the final sum, with
// rounding and clipping in front of the output register.
// Throughput is one beat per cycle while the skid buffer is empty; every
// stage is a full register rank.
// When the receiver stalls, a one-entry skid buffer behind the output register
// absorbs the beat already in flight, and req_ready drops (it is a register
// output) while the pipeline holds. Nothing is lost or repeated.
// Synchronous active-high reset clears all valid bits and the skid buffer;
// the block accepts a beat on the first cycle after reset.
module vector_rotate_about_axis_unit #(
   parameter int COORD_WIDTH   = 32,
   parameter int ANGLE_WIDTH   = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_opcode,
   input  logic [ANGLE_WIDTH-1:0]        req_angle,
   input  logic signed [COORD_WIDTH-1:0] req_vec_x,
   input  logic signed [COORD_WIDTH-1:0] req_vec_y,
   input  logic signed [COORD_WIDTH-1:0] req_vec_z,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0] rsp_out_x,
   output logic signed [COORD_WIDTH-1:0] rsp_out_y,
   output logic signed [COORD_WIDTH-1:0] rsp_out_z,
   output logic                          rsp_saturated
);
   import vrot_pkg::*;

   localparam int NCH = (COORD_WIDTH + SLICE_W - 1) / SLICE_W;
   localparam int AXW = NCH * SLICE_W;
   localparam int PPW = SLICE_W + 1 + TRIG_W;
   localparam int DW  = PPW + 1;
   localparam int SW  = AXW + TRIG_W + 2;
   localparam int PADW = 32 - ANGLE_WIDTH;

   typedef struct packed {
      axis_type                      op;
      quad_type                      quad;
      logic signed [COORD_WIDTH-1:0] vx;
      logic signed [COORD_WIDTH-1:0] vy;
      logic signed [COORD_WIDTH-1:0] vz;
   } meta_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] vx;
      logic signed [COORD_WIDTH-1:0] vy;
      logic signed [COORD_WIDTH-1:0] vz;
      logic                          sat;
   } res_type;

   // Clip a rounded product sum to the coordinate range; top bit flags overflow.
   function automatic logic [COORD_WIDTH:0] clip(input logic signed [SW-1:0] q);
      logic ovf;
      logic [COORD_WIDTH-1:0] val;
      ovf = (q[SW-1:COORD_WIDTH-1] != {(SW-COORD_WIDTH+1){q[SW-1]}});
      if (ovf) begin
         val = {q[SW-1], {(COORD_WIDTH-1){~q[SW-1]}}};
      end else begin
         val = q[COORD_WIDTH-1:0];
      end
      return {ovf, val};
   endfunction

   logic en;

   // CORDIC pipeline
   logic signed [TRIG_W-1:0] cx_in [CORDIC_STAGES+1];
   logic signed [TRIG_W-1:0] cy_in [CORDIC_STAGES+1];
   logic signed [TRIG_W-1:0] cz_in [CORDIC_STAGES+1];
   meta_type                 meta_in [CORDIC_STAGES+1];
   logic [CORDIC_STAGES:0]   cvld_in;
   logic signed [TRIG_W-1:0] cx_ff [CORDIC_STAGES+1];
   logic signed [TRIG_W-1:0] cy_ff [CORDIC_STAGES+1];
   logic signed [TRIG_W-1:0] cz_ff [CORDIC_STAGES+1];
   meta_type                 meta_ff [CORDIC_STAGES+1];
   logic [CORDIC_STAGES:0]   cvld_ff;

   logic [PADW-1:0] zpad;
   assign zpad = '0;

   assign cx_in[0]   = CORDIC_GAIN;
   assign cy_in[0]   = '0;
   assign cz_in[0]   = $signed(TRIG_W'({req_angle[ANGLE_WIDTH-3:0], zpad}));
   assign meta_in[0] = '{op: axis_type'(req_opcode),
                         quad: quad_type'(req_angle[ANGLE_WIDTH-1 -: 2]),
                         vx: req_vec_x, vy: req_vec_y, vz: req_vec_z};
   assign cvld_in[0] = req_valid;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
      logic signed [TRIG_W-1:0] step_z;
      logic signed [TRIG_W-1:0] dx;
      logic signed [TRIG_W-1:0] dy;
      logic                     neg;
      assign step_z = $signed({2'b00, ATAN_TURN32[i]});
      assign dx     = cy_ff[i] >>> i;
      assign dy     = cx_ff[i] >>> i;
      assign neg    = cz_ff[i][TRIG_W-1];
      assign cx_in[i+1]   = neg ? cx_ff[i] + dx : cx_ff[i] - dx;
      assign cy_in[i+1]   = neg ? cy_ff[i] - dy : cy_ff[i] + dy;
      assign cz_in[i+1]   = neg ? cz_ff[i] + step_z : cz_ff[i] - step_z;
      assign meta_in[i+1] = meta_ff[i];
      assign cvld_in[i+1] = cvld_ff[i];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= CORDIC_STAGES; k++) begin
            cx_ff[k]   <= cx_in[k];
            cy_ff[k]   <= cy_in[k];
            cz_ff[k]   <= cz_in[k];
            meta_ff[k] <= meta_in[k];
         end
      end
   end

   // Quadrant restore and operand selection
   logic signed [TRIG_W-1:0]      rc_in, rs_in, rc_ff, rs_ff;
   logic signed [COORD_WIDTH-1:0] ra_in, rb_in, ra_ff, rb_ff;
   meta_type                      rmeta_ff;
   logic                          rvld_ff;

   always_comb begin
      case (meta_ff[CORDIC_STAGES].quad)
         QUAD_0: begin
            rc_in = cx_ff[CORDIC_STAGES];
            rs_in = cy_ff[CORDIC_STAGES];
         end
         QUAD_1: begin
            rc_in = -cy_ff[CORDIC_STAGES];
            rs_in = cx_ff[CORDIC_STAGES];
         end
         QUAD_2: begin
            rc_in = -cx_ff[CORDIC_STAGES];
            rs_in = -cy_ff[CORDIC_STAGES];
         end
         default: begin
            rc_in = cy_ff[CORDIC_STAGES];
            rs_in = -cx_ff[CORDIC_STAGES];
         end
      endcase
      case (meta_ff[CORDIC_STAGES].op)
         OP_PITCH: begin
            ra_in = meta_ff[CORDIC_STAGES].vy;
            rb_in = meta_ff[CORDIC_STAGES].vz;
         end
         OP_YAW: begin
            ra_in = meta_ff[CORDIC_STAGES].vz;
            rb_in = meta_ff[CORDIC_STAGES].vx;
         end
         default: begin
            ra_in = meta_ff[CORDIC_STAGES].vx;
            rb_in = meta_ff[CORDIC_STAGES].vy;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rc_ff    <= rc_in;
         rs_ff    <= rs_in;
         ra_ff    <= ra_in;
         rb_ff    <= rb_in;
         rmeta_ff <= meta_ff[CORDIC_STAGES];
      end
   end

   // Slice multiply: a*c, b*s, a*s, b*c per 16-bit slice of a and b
   logic signed [AXW-1:0] a_ext, b_ext;
   logic signed [PPW-1:0] pac_in [NCH];
   logic signed [PPW-1:0] pbs_in [NCH];
   logic signed [PPW-1:0] pas_in [NCH];
   logic signed [PPW-1:0] pbc_in [NCH];
   logic signed [PPW-1:0] pac_ff [NCH];
   logic signed [PPW-1:0] pbs_ff [NCH];
   logic signed [PPW-1:0] pas_ff [NCH];
   logic signed [PPW-1:0] pbc_ff [NCH];
   meta_type              m1meta_ff;
   logic                  m1vld_ff;

   assign a_ext = AXW'(ra_ff);
   assign b_ext = AXW'(rb_ff);

   for (genvar j = 0; j < NCH; j++) begin : g_slice
      logic signed [SLICE_W:0] ach, bch;
      if (j == NCH - 1) begin : g_top
         // top slice carries the sign
         assign ach = $signed({a_ext[SLICE_W*j+SLICE_W-1], a_ext[SLICE_W*j +: SLICE_W]});
         assign bch = $signed({b_ext[SLICE_W*j+SLICE_W-1], b_ext[SLICE_W*j +: SLICE_W]});
      end else begin : g_low
         assign ach = $signed({1'b0, a_ext[SLICE_W*j +: SLICE_W]});
         assign bch = $signed({1'b0, b_ext[SLICE_W*j +: SLICE_W]});
      end
      assign pac_in[j] = PPW'(ach) * PPW'(rc_ff);
      assign pbs_in[j] = PPW'(bch) * PPW'(rs_ff);
      assign pas_in[j] = PPW'(ach) * PPW'(rs_ff);
      assign pbc_in[j] = PPW'(bch) * PPW'(rc_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NCH; k++) begin
            pac_ff[k] <= pac_in[k];
            pbs_ff[k] <= pbs_in[k];
            pas_ff[k] <= pas_in[k];
            pbc_ff[k] <= pbc_in[k];
         end
         m1meta_ff <= rmeta_ff;
      end
   end

   // Slice combine
   logic signed [DW-1:0] d1_ff [NCH];
   logic signed [DW-1:0] d2_ff [NCH];
   meta_type             m2meta_ff;
   logic                 m2vld_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NCH; k++) begin
            d1_ff[k] <= DW'(pac_ff[k]) - DW'(pbs_ff[k]);
            d2_ff[k] <= DW'(pas_ff[k]) + DW'(pbc_ff[k]);
         end
         m2meta_ff <= m1meta_ff;
      end
   end

   // Full product sums with the rounding offset
   logic signed [SW-1:0] sum1_in, sum2_in, sum1_ff, sum2_ff;
   meta_type             m3meta_ff;
   logic                 m3vld_ff;

   always_comb begin
      sum1_in = SW'(HALF_Q30);
      sum2_in = SW'(HALF_Q30);
      for (int k = 0; k < NCH; k++) begin
         sum1_in = sum1_in + (SW'(d1_ff[k]) <<< (SLICE_W * k));
         sum2_in = sum2_in + (SW'(d2_ff[k]) <<< (SLICE_W * k));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum1_ff   <= sum1_in;
         sum2_ff   <= sum2_in;
         m3meta_ff <= m2meta_ff;
      end
   end

   // Round, clip and place the results on their axes
   logic [COORD_WIDTH:0] clip1, clip2;
   res_type              res;

   assign clip1 = clip(sum1_ff >>> TRIG_FRAC);
   assign clip2 = clip(sum2_ff >>> TRIG_FRAC);

   always_comb begin
      res.vx  = m3meta_ff.vx;
      res.vy  = m3meta_ff.vy;
      res.vz  = m3meta_ff.vz;
      res.sat = clip1[COORD_WIDTH] | clip2[COORD_WIDTH];
      case (m3meta_ff.op)
         OP_PITCH: begin
            res.vy = clip1[COORD_WIDTH-1:0];
            res.vz = clip2[COORD_WIDTH-1:0];
         end
         OP_YAW: begin
            res.vz = clip1[COORD_WIDTH-1:0];
            res.vx = clip2[COORD_WIDTH-1:0];
         end
         OP_ROLL: begin
            res.vx = clip1[COORD_WIDTH-1:0];
            res.vy = clip2[COORD_WIDTH-1:0];
         end
         default: begin
            res.sat = 1'b0;
         end
      endcase
   end

   // Valid bits of all pipeline stages
   always_ff @(posedge clock) begin
      if (reset) begin
         cvld_ff  <= '0;
         rvld_ff  <= 1'b0;
         m1vld_ff <= 1'b0;
         m2vld_ff <= 1'b0;
         m3vld_ff <= 1'b0;
      end else if (en) begin
         cvld_ff  <= cvld_in;
         rvld_ff  <= cvld_ff[CORDIC_STAGES];
         m1vld_ff <= rvld_ff;
         m2vld_ff <= m1vld_ff;
         m3vld_ff <= m2vld_ff;
      end
   end

   // Output register with one-entry skid buffer
   res_type out_in, out_ff, skid_in, skid_ff;
   logic    out_vld_in, out_vld_ff, skid_vld_in, skid_vld_ff;
   logic    push, pop;

   assign en        = ~skid_vld_ff;
   assign req_ready = en;
   assign push      = en & m3vld_ff;
   assign pop       = out_vld_ff & rsp_ready;

   always_comb begin
      out_in      = out_ff;
      skid_in     = skid_ff;
      out_vld_in  = out_vld_ff;
      skid_vld_in = skid_vld_ff;
      if (push) begin
         if (!out_vld_ff || pop) begin
            out_in     = res;
            out_vld_in = 1'b1;
         end else begin
            // hold the new beat until the receiver takes the waiting one
            skid_in     = res;
            skid_vld_in = 1'b1;
         end
      end else if (pop) begin
         if (skid_vld_ff) begin
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end else begin
            out_vld_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_out_x     = out_ff.vx;
   assign rsp_out_y     = out_ff.vy;
   assign rsp_out_z     = out_ff.vz;
   assign rsp_saturated = out_ff.sat;

endmodule

// ===== dv/vector_rotate_about_axis_unit_tb.sv =====
// Self-checking testbench for the vector rotation unit: prediction, scoreboard and drivers.
package vrot_tb_pkg;
   import vrot_pkg::*;

   localparam int COORD_W  = 32;
   localparam int ANGLE_W  = 16;
   localparam int STAGES_N = 16;
   localparam int Q30_FRAC = 30;
   localparam longint START_GAIN = 64'sd652032874;

   localparam logic signed [127:0] ROUND_HALF = 128'sd1 <<< (Q30_FRAC - 1);
   localparam logic signed [127:0] COORD_MAX  = (128'sd1 <<< (COORD_W - 1)) - 128'sd1;
   localparam logic signed [127:0] COORD_MIN  = -COORD_MAX - 128'sd1;

   // atan(2^-i) in units of 2^-32 turn
   localparam longint ARCTAN_TURN[32] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
      64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
      64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005,
      64'h00000003, 64'h00000001, 64'h00000001, 64'h00000000
   };

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic                      sat;
   } rotated_vec_type;

   class rotation_scoreboard;
      rotated_vec_type expected_q[$];
      int unsigned     mismatches;

      function new();
         mismatches = 0;
      endfunction

      // Cosine and sine in Q2.30 of a binary angle, quadrant folded out and restored
      function void angle_trig(input logic [ANGLE_W-1:0] ang,
                               output longint cos_v, output longint sin_v);
         longint   cx, cy, cz, dx, dy;
         quad_type quad;
         int       k;
         quad = quad_type'(ang[ANGLE_W-1 -: 2]);
         cz   = longint'(ang[ANGLE_W-3:0]) << (32 - ANGLE_W);
         cx   = START_GAIN;
         cy   = 0;
         for (int i = 0; i < STAGES_N; i++) begin
            k  = i % 32;
            dx = cy >>> k;
            dy = cx >>> k;
            if (cz >= 0) begin
               cx = cx - dx;
               cy = cy + dy;
               cz = cz - ARCTAN_TURN[k];
            end else begin
               cx = cx + dx;
               cy = cy - dy;
               cz = cz + ARCTAN_TURN[k];
            end
         end
         case (quad)
            QUAD_0: begin cos_v = cx;  sin_v = cy;  end
            QUAD_1: begin cos_v = -cy; sin_v = cx;  end
            QUAD_2: begin cos_v = -cx; sin_v = -cy; end
            default: begin cos_v = cy; sin_v = -cx; end
         endcase
      endfunction

      // round(a*c - b*s) / 2^30, half up, clipped to the coordinate range
      function logic signed [COORD_W-1:0] round_clip(input longint a, input longint b,
                                                     input longint c, input longint s,
                                                     inout bit clipped);
         logic signed [127:0] wa, wb, wc, ws, acc;
         wa  = a;
         wb  = b;
         wc  = c;
         ws  = s;
         acc = (wa * wc - wb * ws + ROUND_HALF) >>> Q30_FRAC;
         if (acc > COORD_MAX) begin
            acc     = COORD_MAX;
            clipped = 1'b1;
         end else if (acc < COORD_MIN) begin
            acc     = COORD_MIN;
            clipped = 1'b1;
         end
         return acc[COORD_W-1:0];
      endfunction

      function rotated_vec_type rotate(input axis_type op, input logic [ANGLE_W-1:0] ang,
                                       input logic signed [COORD_W-1:0] vx,
                                       input logic signed [COORD_W-1:0] vy,
                                       input logic signed [COORD_W-1:0] vz);
         rotated_vec_type r;
         longint          c, s;
         bit              clipped;
         clipped = 1'b0;
         angle_trig(ang, c, s);
         r.x = vx;
         r.y = vy;
         r.z = vz;
         case (op)
            OP_PITCH: begin
               r.y = round_clip(vy, vz, c, s, clipped);
               r.z = round_clip(vy, vz, s, -c, clipped);
            end
            OP_YAW: begin
               r.z = round_clip(vz, vx, c, s, clipped);
               r.x = round_clip(vz, vx, s, -c, clipped);
            end
            OP_ROLL: begin
               r.x = round_clip(vx, vy, c, s, clipped);
               r.y = round_clip(vx, vy, s, -c, clipped);
            end
            default: ;
         endcase
         r.sat = clipped;
         return r;
      endfunction

      function void note_request(input axis_type op, input logic [ANGLE_W-1:0] ang,
                                 input logic signed [COORD_W-1:0] vx,
                                 input logic signed [COORD_W-1:0] vy,
                                 input logic signed [COORD_W-1:0] vz);
         expected_q.push_back(rotate(op, ang, vx, vy, vz));
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void compare_field(input string name, input longint want, input longint got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(input logic signed [COORD_W-1:0] ox,
                                   input logic signed [COORD_W-1:0] oy,
                                   input logic signed [COORD_W-1:0] oz,
                                   input logic sat);
         rotated_vec_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: response beat with none outstanding, expected none actual %0d %0d %0d %0b",
                     $time, ox, oy, oz, sat);
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("out_x", want.x, ox);
         compare_field("out_y", want.y, oy);
         compare_field("out_z", want.z, oz);
         compare_field("saturated", want.sat, sat);
      endfunction
   endclass
endpackage

module vector_rotate_about_axis_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import vrot_pkg::*;
   import vrot_tb_pkg::*;

   localparam int RANDOM_ITEMS = 1700;
   localparam int DRAIN_CYCLES = 40;

   localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam logic signed [COORD_W-1:0] ONE_Q16 = 32'sd65536;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [1:0]                req_opcode = OP_PITCH;
   logic [ANGLE_W-1:0]        req_angle = '0;
   logic signed [COORD_W-1:0] req_vec_x = '0;
   logic signed [COORD_W-1:0] req_vec_y = '0;
   logic signed [COORD_W-1:0] req_vec_z = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [COORD_W-1:0] rsp_out_x;
   logic signed [COORD_W-1:0] rsp_out_y;
   logic signed [COORD_W-1:0] rsp_out_z;
   logic                      rsp_saturated;

   rotation_scoreboard board;
   bit                 tx_steady = 1'b0;

   vector_rotate_about_axis_unit #(
      .COORD_WIDTH   (COORD_W),
      .ANGLE_WIDTH   (ANGLE_W),
      .CORDIC_STAGES (STAGES_N)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_angle     (req_angle),
      .req_vec_x     (req_vec_x),
      .req_vec_y     (req_vec_y),
      .req_vec_z     (req_vec_z),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_z     (rsp_out_z),
      .rsp_saturated (rsp_saturated)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Present one beat after a random gap (none while tx_steady is set) and hold it until accepted
   task automatic send_request(input axis_type op, input logic [ANGLE_W-1:0] ang,
                               input logic signed [COORD_W-1:0] vx,
                               input logic signed [COORD_W-1:0] vy,
                               input logic signed [COORD_W-1:0] vz);
      int unsigned gap;
      gap = tx_steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_angle  <= ang;
      req_vec_x  <= vx;
      req_vec_y  <= vy;
      req_vec_z  <= vz;
      do @(posedge clock); while (!req_ready);
      board.note_request(op, ang, vx, vy, vz);
   endtask

   // Drop valid and hold until every outstanding rotation has returned
   task automatic drain_results();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   function automatic logic signed [COORD_W-1:0] pick_coord();
      logic signed [COORD_W-1:0] v;
      case ($urandom_range(0, 7))
         0, 1, 2: v = $urandom;
         3, 4:    v = $urandom_range(0, 2097151) - 1048576;
         5: begin
            case ($urandom_range(0, 4))
               0: v = CMAX;
               1: v = CMIN;
               2: v = '0;
               3: v = -1;
               default: v = 1;
            endcase
         end
         default: begin
            // large magnitude, likely to clip after rotation
            v = 32'h4000_0000 | ($urandom & 32'h3FFF_FFFF);
            if ($urandom_range(0, 1)) v = -v;
         end
      endcase
      return v;
   endfunction

   function automatic logic [ANGLE_W-1:0] pick_angle();
      logic [ANGLE_W-1:0] a;
      if ($urandom_range(0, 3) != 0) begin
         a = ANGLE_W'($urandom_range(0, (1 << ANGLE_W) - 1));
      end else begin
         // land on or beside a quadrant boundary
         a = {2'($urandom_range(0, 3)), {(ANGLE_W-2){1'b0}}};
         a = a + ANGLE_W'($urandom_range(0, 2)) - 1'b1;
      end
      return a;
   endfunction

   function automatic axis_type pick_axis();
      int unsigned r;
      r = $urandom_range(0, 9);
      return (r == 9) ? OP_PASS : axis_type'(r % 3);
   endfunction

   // Response side: random stall before each beat, with calm stretches
   initial begin : rsp_side
      int unsigned stall;
      int unsigned calm_left;
      bit          calm;
      calm_left = 0;
      calm      = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (calm_left == 0) begin
            calm      = ($urandom_range(0, 3) == 0);
            calm_left = 40;
         end
         calm_left--;
         stall = calm ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         board.check_response(rsp_out_x, rsp_out_y, rsp_out_z, rsp_saturated);
      end
   end

   initial begin : req_side
      logic [ANGLE_W-1:0] quarter [5];
      axis_type           op;
      board      = new();
      quarter[0] = '0;
      quarter[1] = 16'h4000;
      quarter[2] = 16'h8000;
      quarter[3] = 16'hC000;
      quarter[4] = 16'hFFFF;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // every axis at the quadrant edges and the top angle
      for (int a = 0; a < 3; a++) begin
         op = axis_type'(a);
         for (int q = 0; q < 5; q++)
            send_request(op, quarter[q], ONE_Q16, 2 * ONE_Q16, -3 * ONE_Q16);
      end
      // unused axis code passes the vector straight through
      send_request(OP_PASS, 16'h3039, CMAX, CMIN, -1);
      send_request(OP_PASS, 16'hFFFF, '0, 1, CMAX);
      // clipping on each axis, then a zero vector
      send_request(OP_ROLL, 16'h2000, CMAX, CMAX, CMIN);
      send_request(OP_PITCH, 16'h2000, CMAX, CMIN, CMIN);
      send_request(OP_YAW, 16'hE000, CMIN, CMAX, CMAX);
      send_request(OP_PITCH, 16'h8000, CMIN, CMIN, '0);
      send_request(OP_ROLL, 16'h8000, CMIN, CMIN, CMIN);
      send_request(OP_YAW, 16'h03E8, '0, '0, '0);
      drain_results();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) tx_steady = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_ITEMS / 2) drain_results();
         send_request(pick_axis(), pick_angle(), pick_coord(), pick_coord(), pick_coord());
      end
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

// ===== vector_rotate_about_axis_unit.f =====
design/vrot_pkg.sv
design/vector_rotate_about_axis_unit.sv
dv/vector_rotate_about_axis_unit_tb.sv
